[rtl/lzwd_pkg.sv]
// Shared types and constants for the LZ77 window decompressor.
package lzwd_pkg;

   // Field widths fixed by the compressed format.
   localparam int BYTE_W            = 8;
   localparam int SIZE_W            = 24;
   localparam int DIST_W            = 12;
   localparam int LEN_W             = 5;
   localparam int FLAG_CNT_W        = 4;
   localparam int FLAGS_PER_BYTE    = 8;
   localparam int LEN_BIAS          = 3;
   localparam int HISTORY_DEPTH_DEF = 4096;

   // Position in the compressed stream.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SIZE0,
      PH_SIZE1,
      PH_SIZE2,
      PH_FLAG,
      PH_LIT,
      PH_PAIR_HI,
      PH_PAIR_LO
   } phase_type;

   // Sequencer state: history clearing, parsing beats, or replaying a match.
   typedef enum logic [1:0] {
      CTL_CLEAR,
      CTL_PARSE,
      CTL_COPY
   } ctl_state_type;

endpackage

[rtl/lzwd_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module lzwd_ram #(
   parameter int WIDTH = lzwd_pkg::BYTE_W,
   parameter int DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lz77_window_decompressor.sv]
// A literal byte reaches rsp in the cycle after its beat is taken; a match's first byte
// is read from history as the copy state begins, then registered onto rsp, and one byte
// a cycle follows while rsp is not stalled. Input takes one beat per cycle while rsp is
// not stalled; after a pair's second byte it is held while n = 3..18 bytes (fewer at
// stream end) are copied through the single history read port. Reset: synchronous; a
// clearing pass then zeroes all HISTORY_DEPTH (4096) slots while req_stall stays high.
module lz77_window_decompressor #(
   parameter int HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lzwd_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                        req_stream_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lzwd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_run_end,
   output logic                        rsp_stream_end
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   // Control state.
   lzwd_pkg::ctl_state_type ctl_state_ff, ctl_state_in;
   lzwd_pkg::phase_type     phase_ff, phase_in;
   logic [AW-1:0]                       clr_addr_ff, clr_addr_in;
   logic [lzwd_pkg::SIZE_W-1:0]         bytes_left_ff, bytes_left_in;
   logic [lzwd_pkg::BYTE_W-1:0]         flag_bits_ff, flag_bits_in;
   logic [lzwd_pkg::FLAG_CNT_W-1:0]     bits_left_ff, bits_left_in;
   logic [lzwd_pkg::BYTE_W-1:0]         pair_high_ff, pair_high_in;
   logic [AW-1:0]                       write_pos_ff, write_pos_in;
   logic [lzwd_pkg::LEN_W-1:0]          copy_cnt_ff, copy_cnt_in;
   logic [lzwd_pkg::DIST_W-1:0]         dist_m1_ff, dist_m1_in;
   logic                                fwd_hit_ff, fwd_hit_in;
   logic [lzwd_pkg::BYTE_W-1:0]         fwd_data_ff, fwd_data_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [lzwd_pkg::BYTE_W-1:0]         rsp_out_byte_ff;
   logic                                rsp_run_end_ff;
   logic                                rsp_stream_end_ff;

   // Datapath and handshake signals.
   logic                            can_emit;
   logic                            req_accept;
   logic                            data_beat;
   logic                            lit_emit;
   logic                            copy_emit;
   logic                            emit;
   logic                            emit_last;
   logic [lzwd_pkg::BYTE_W-1:0]     emit_byte;
   logic [lzwd_pkg::BYTE_W-1:0]     copy_byte;
   logic [lzwd_pkg::SIZE_W-1:0]     left_dec;
   logic [lzwd_pkg::BYTE_W-1:0]     flags_shifted;
   logic [lzwd_pkg::FLAG_CNT_W-1:0] bits_dec;
   lzwd_pkg::phase_type             phase_after_item;
   logic [lzwd_pkg::SIZE_W-1:0]     size_full;
   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_wr_addr;
   logic [lzwd_pkg::BYTE_W-1:0]     ram_wr_data;
   logic [AW-1:0]                   ram_rd_addr;
   logic [lzwd_pkg::BYTE_W-1:0]     ram_rd_data;

   // History store.
   lzwd_ram #(
      .WIDTH (lzwd_pkg::BYTE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshake, emit selection and history port control.
   always_comb begin
      can_emit   = !rsp_valid_ff || !rsp_stall;
      req_stall  = (ctl_state_ff != lzwd_pkg::CTL_PARSE) || !can_emit;
      req_accept = req_valid && !req_stall;
      data_beat  = req_accept && !req_stream_start;
      lit_emit   = data_beat && (phase_ff == lzwd_pkg::PH_LIT);
      copy_emit  = (ctl_state_ff == lzwd_pkg::CTL_COPY) && can_emit;
      emit       = lit_emit || copy_emit;

      // A read that met a write to the same slot takes the written byte.
      copy_byte = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
      emit_byte = lit_emit ? req_in_byte : copy_byte;
      left_dec  = bytes_left_ff - lzwd_pkg::SIZE_W'(1);
      emit_last = lit_emit || (copy_cnt_ff == lzwd_pkg::LEN_W'(1)) ||
                  (left_dec == '0);

      if (ctl_state_ff == lzwd_pkg::CTL_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = emit;
         ram_wr_addr = write_pos_ff;
         ram_wr_data = emit_byte;
      end

      // Source of the next copied byte: distance back from the next write slot.
      ram_rd_addr = write_pos_in - AW'(dist_m1_in) - AW'(1);
      fwd_hit_in  = ram_wr_en && (ram_rd_addr == ram_wr_addr);
      fwd_data_in = ram_wr_data;

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   // Flag byte bookkeeping after one literal or pair.
   always_comb begin
      flags_shifted = {flag_bits_ff[lzwd_pkg::BYTE_W-2:0], 1'b0};
      bits_dec      = bits_left_ff - lzwd_pkg::FLAG_CNT_W'(1);
      if (bits_dec == '0) begin
         phase_after_item = lzwd_pkg::PH_FLAG;
      end else if (flags_shifted[lzwd_pkg::BYTE_W-1]) begin
         phase_after_item = lzwd_pkg::PH_PAIR_HI;
      end else begin
         phase_after_item = lzwd_pkg::PH_LIT;
      end
      size_full = {req_in_byte, bytes_left_ff[2*lzwd_pkg::BYTE_W-1:0]};
   end

   // Next state of the sequencer and the stream parser.
   always_comb begin
      ctl_state_in  = ctl_state_ff;
      phase_in      = phase_ff;
      clr_addr_in   = clr_addr_ff;
      bytes_left_in = bytes_left_ff;
      flag_bits_in  = flag_bits_ff;
      bits_left_in  = bits_left_ff;
      pair_high_in  = pair_high_ff;
      write_pos_in  = emit ? write_pos_ff + AW'(1) : write_pos_ff;
      copy_cnt_in   = copy_cnt_ff;
      dist_m1_in    = dist_m1_ff;

      case (ctl_state_ff)
         lzwd_pkg::CTL_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(HISTORY_DEPTH - 1)) begin
               ctl_state_in = lzwd_pkg::CTL_PARSE;
            end
         end
         lzwd_pkg::CTL_PARSE: begin
            if (req_accept && req_stream_start) begin
               phase_in      = lzwd_pkg::PH_SIZE0;
               bytes_left_in = '0;
               bits_left_in  = '0;
               flag_bits_in  = '0;
            end else if (data_beat) begin
               case (phase_ff)
                  lzwd_pkg::PH_SIZE0: begin
                     bytes_left_in = lzwd_pkg::SIZE_W'(req_in_byte);
                     phase_in      = lzwd_pkg::PH_SIZE1;
                  end
                  lzwd_pkg::PH_SIZE1: begin
                     bytes_left_in[2*lzwd_pkg::BYTE_W-1:lzwd_pkg::BYTE_W] = req_in_byte;
                     phase_in = lzwd_pkg::PH_SIZE2;
                  end
                  lzwd_pkg::PH_SIZE2: begin
                     bytes_left_in = size_full;
                     phase_in      = (size_full != '0) ? lzwd_pkg::PH_FLAG
                                                       : lzwd_pkg::PH_IDLE;
                  end
                  lzwd_pkg::PH_FLAG: begin
                     flag_bits_in = req_in_byte;
                     bits_left_in = lzwd_pkg::FLAG_CNT_W'(lzwd_pkg::FLAGS_PER_BYTE);
                     phase_in     = req_in_byte[lzwd_pkg::BYTE_W-1] ? lzwd_pkg::PH_PAIR_HI
                                                                    : lzwd_pkg::PH_LIT;
                  end
                  lzwd_pkg::PH_LIT: begin
                     flag_bits_in  = flags_shifted;
                     bits_left_in  = bits_dec;
                     bytes_left_in = left_dec;
                     phase_in      = (left_dec == '0) ? lzwd_pkg::PH_IDLE : phase_after_item;
                  end
                  lzwd_pkg::PH_PAIR_HI: begin
                     pair_high_in = req_in_byte;
                     phase_in     = lzwd_pkg::PH_PAIR_LO;
                  end
                  lzwd_pkg::PH_PAIR_LO: begin
                     dist_m1_in   = {pair_high_ff[lzwd_pkg::DIST_W-lzwd_pkg::BYTE_W-1:0],
                                     req_in_byte};
                     copy_cnt_in  = lzwd_pkg::LEN_W'(pair_high_ff[lzwd_pkg::BYTE_W-1:4]) +
                                    lzwd_pkg::LEN_W'(lzwd_pkg::LEN_BIAS);
                     flag_bits_in = flags_shifted;
                     bits_left_in = bits_dec;
                     phase_in     = phase_after_item;
                     ctl_state_in = lzwd_pkg::CTL_COPY;
                  end
                  default: begin
                     // Idle: bytes outside a stream are dropped.
                  end
               endcase
            end
         end
         lzwd_pkg::CTL_COPY: begin
            if (copy_emit) begin
               bytes_left_in = left_dec;
               copy_cnt_in   = copy_cnt_ff - lzwd_pkg::LEN_W'(1);
               if (left_dec == '0) begin
                  phase_in = lzwd_pkg::PH_IDLE;
               end
               if (emit_last) begin
                  ctl_state_in = lzwd_pkg::CTL_PARSE;
               end
            end
         end
         default: begin
            ctl_state_in = lzwd_pkg::CTL_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff  <= lzwd_pkg::CTL_CLEAR;
         phase_ff      <= lzwd_pkg::PH_IDLE;
         clr_addr_ff   <= '0;
         bytes_left_ff <= '0;
         flag_bits_ff  <= '0;
         bits_left_ff  <= '0;
         pair_high_ff  <= '0;
         write_pos_ff  <= '0;
         fwd_hit_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ctl_state_ff  <= ctl_state_in;
         phase_ff      <= phase_in;
         clr_addr_ff   <= clr_addr_in;
         bytes_left_ff <= bytes_left_in;
         flag_bits_ff  <= flag_bits_in;
         bits_left_ff  <= bits_left_in;
         pair_high_ff  <= pair_high_in;
         write_pos_ff  <= write_pos_in;
         fwd_hit_ff    <= fwd_hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: match parameters, forwarded byte and the result beat.
   always_ff @(posedge clock) begin
      copy_cnt_ff <= copy_cnt_in;
      dist_m1_ff  <= dist_m1_in;
      fwd_data_ff <= fwd_data_in;
      if (emit) begin
         rsp_out_byte_ff   <= emit_byte;
         rsp_run_end_ff    <= emit_last;
         rsp_stream_end_ff <= (left_dec == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_run_end    = rsp_run_end_ff;
   assign rsp_stream_end = rsp_stream_end_ff;

endmodule

[rtl/lzwd_checker.sv]
// Port-level checks on the decompressor.
module lzwd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [lzwd_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                        rsp_run_end,
   input logic                        rsp_stream_end
);

   // A stalled result beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result beat changed");

   // The final byte of a stream always closes the run of its input beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_end)
      else $error("stream end without run end");

   // The history clearing pass holds off input straight after reset.
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken during history clearing");

   // While a match is being replayed no new input is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> req_stall)
      else $error("input taken in the middle of a match");

   // A taken match byte that is not the last is followed at once by the next.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_end |=> rsp_valid)
      else $error("gap inside a match run");

endmodule

bind lz77_window_decompressor lzwd_checker u_lzwd_checker (.*);

[bench/lz77_window_decompressor_tb.sv]
`timescale 1ns / 1ps

module lz77_window_decompressor_tb;

   localparam int RANDOM_BEATS = 80;
   localparam int QUIET_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 40;

   // One beat of the compressed stream as the sender holds it.
   typedef struct packed {
      logic                        start;
      logic [lzwd_pkg::BYTE_W-1:0] data;
   } stream_beat_type;

   // One decompressed byte as the block should present it.
   typedef struct packed {
      logic [lzwd_pkg::BYTE_W-1:0] data;
      logic                        run_end;
      logic                        stream_end;
   } out_beat_type;

   // Tracks the decoder state beat by beat and holds the bytes still owed.
   class window_scoreboard;
      lzwd_pkg::phase_type         phase;
      logic [lzwd_pkg::SIZE_W-1:0] bytes_left;
      logic [7:0]                  flag_bits;
      logic [3:0]                  bits_left;
      logic [7:0]                  pair_high;
      logic [lzwd_pkg::DIST_W-1:0] write_pos;
      logic [lzwd_pkg::BYTE_W-1:0] history [lzwd_pkg::HISTORY_DEPTH_DEF];
      out_beat_type                owed_bytes[$];
      int                          errors;
      int                          beats_seen;
      int                          streams_opened;
      int                          copies_decoded;
      int                          bytes_checked;

      function new();
         phase          = lzwd_pkg::PH_IDLE;
         bytes_left     = '0;
         flag_bits      = '0;
         bits_left      = '0;
         pair_high      = '0;
         write_pos      = '0;
         errors         = 0;
         beats_seen     = 0;
         streams_opened = 0;
         copies_decoded = 0;
         bytes_checked  = 0;
         foreach (history[i]) history[i] = '0;
      endfunction

      // Writes one output byte into the window and owes it to the receiver.
      function void produce_byte(logic [lzwd_pkg::BYTE_W-1:0] value);
         out_beat_type ob;
         history[write_pos] = value;
         write_pos  = write_pos + lzwd_pkg::DIST_W'(1);
         bytes_left = bytes_left - lzwd_pkg::SIZE_W'(1);
         ob.data       = value;
         ob.run_end    = 1'b0;
         ob.stream_end = (bytes_left == '0);
         owed_bytes.push_back(ob);
      endfunction

      // Moves on to the next flag bit, or asks for a fresh flag byte.
      function void next_flag();
         flag_bits = flag_bits << 1;
         bits_left = bits_left - 4'd1;
         if (bits_left != '0)
            phase = flag_bits[7] ? lzwd_pkg::PH_PAIR_HI : lzwd_pkg::PH_LIT;
         else
            phase = lzwd_pkg::PH_FLAG;
      endfunction

      // Decodes one accepted input beat and queues the bytes it produces.
      function void decode_beat(logic [lzwd_pkg::BYTE_W-1:0] data, logic start);
         int                          held;
         int                          copy_len;
         logic [lzwd_pkg::DIST_W-1:0] rd_pos;
         held = owed_bytes.size();
         beats_seen++;
         if (start) begin
            // A start beat always opens a new header, even mid-stream.
            phase      = lzwd_pkg::PH_SIZE0;
            bytes_left = '0;
            bits_left  = '0;
            flag_bits  = '0;
            streams_opened++;
            return;
         end
         case (phase)
            lzwd_pkg::PH_SIZE0: begin
               bytes_left = {16'h0000, data};
               phase      = lzwd_pkg::PH_SIZE1;
            end
            lzwd_pkg::PH_SIZE1: begin
               bytes_left[15:8] = data;
               phase            = lzwd_pkg::PH_SIZE2;
            end
            lzwd_pkg::PH_SIZE2: begin
               bytes_left[23:16] = data;
               phase = (bytes_left != '0) ? lzwd_pkg::PH_FLAG : lzwd_pkg::PH_IDLE;
            end
            lzwd_pkg::PH_FLAG: begin
               flag_bits = data;
               bits_left = 4'd8;
               phase     = data[7] ? lzwd_pkg::PH_PAIR_HI : lzwd_pkg::PH_LIT;
            end
            lzwd_pkg::PH_LIT: begin
               produce_byte(data);
               next_flag();
            end
            lzwd_pkg::PH_PAIR_HI: begin
               pair_high = data;
               phase     = lzwd_pkg::PH_PAIR_LO;
            end
            lzwd_pkg::PH_PAIR_LO: begin
               // The copy is cut short where the stream runs out.
               copy_len = int'(pair_high[7:4]) + lzwd_pkg::LEN_BIAS;
               copies_decoded++;
               while (copy_len > 0 && bytes_left != '0) begin
                  rd_pos = write_pos - {pair_high[3:0], data} - 12'd1;
                  produce_byte(history[rd_pos]);
                  copy_len--;
               end
               next_flag();
            end
            default: ;
         endcase
         if (bytes_left == '0 && phase >= lzwd_pkg::PH_FLAG)
            phase = lzwd_pkg::PH_IDLE;
         if (owed_bytes.size() > held)
            owed_bytes[$].run_end = 1'b1;
      endfunction

      // Compares one received byte with the oldest one owed.
      function void match_output(logic [lzwd_pkg::BYTE_W-1:0] data, logic run_end,
                                 logic stream_end);
         out_beat_type ob;
         bytes_checked++;
         if (owed_bytes.size() == 0) begin
            $display("%0t: unexpected output beat: expected none, got out_byte %02h %s %b %s %b",
                     $time, data, "run_end", run_end, "stream_end", stream_end);
            errors++;
            return;
         end
         ob = owed_bytes.pop_front();
         if (data !== ob.data) begin
            $display("%0t: out_byte mismatch: expected %02h, got %02h",
                     $time, ob.data, data);
            errors++;
         end
         if (run_end !== ob.run_end) begin
            $display("%0t: run_end mismatch: expected %b, got %b",
                     $time, ob.run_end, run_end);
            errors++;
         end
         if (stream_end !== ob.stream_end) begin
            $display("%0t: stream_end mismatch: expected %b, got %b",
                     $time, ob.stream_end, stream_end);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [lzwd_pkg::BYTE_W-1:0] req_in_byte;
   logic                        req_stream_start;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [lzwd_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                        rsp_run_end;
   logic                        rsp_stream_end;

   window_scoreboard sb = new();
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               quiet_cycles   = 0;

   lz77_window_decompressor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_end      (rsp_run_end),
      .rsp_stream_end   (rsp_stream_end)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls at random, at the rate of the current phase.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = (int'($urandom_range(0, 99)) < recv_stall_pct);
      end
   end

   // Both channels are sampled at the rising edge; the watchdog counts quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.match_output(rsp_out_byte, rsp_run_end, rsp_stream_end);
         if (req_valid && !req_stall)
            sb.decode_beat(req_in_byte, req_stream_start);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("lz77_window_decompressor_tb: errors");
            $finish;
         end
      end
   end

   // Offers one beat, idling first at the current rate, and holds it until taken.
   task automatic send_beat(input logic [lzwd_pkg::BYTE_W-1:0] data, input logic start);
      @(negedge clock);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_in_byte      = data;
      req_stream_start = start;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops sending and waits until every owed byte has come out.
   task automatic drain_outputs();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.owed_bytes.size() != 0)
         @(negedge clock);
   endtask

   // Picks a back-reference distance, mostly short, sometimes across the whole window.
   function automatic int pick_distance();
      int r;
      r = int'($urandom_range(0, 9));
      if (r < 6)
         return int'($urandom_range(1, 16));
      else if (r < 9)
         return int'($urandom_range(1, 512));
      return int'($urandom_range(1, lzwd_pkg::HISTORY_DEPTH_DEF));
   endfunction

   // Builds one compressed stream with random literals and copies; some are cut short
   // or announce a size far larger than what follows.
   function automatic void build_stream(ref stream_beat_type beats[$]);
      stream_beat_type             sb_beat;
      logic [lzwd_pkg::SIZE_W-1:0] size_field;
      logic [7:0]                  flags;
      logic [lzwd_pkg::DIST_W-1:0] dist_code;
      logic [3:0]                  len_code;
      int                          target;
      int                          produced;
      int                          r;
      beats.delete();
      r = int'($urandom_range(0, 99));
      if (r < 6) begin
         size_field = '0;
         target     = 0;
      end else if (r < 14) begin
         size_field = lzwd_pkg::SIZE_W'($urandom());
         size_field[23:16] = 8'($urandom_range(1, 255));
         target     = int'($urandom_range(3, 20));
      end else begin
         size_field = lzwd_pkg::SIZE_W'($urandom_range(1, 24));
         target     = int'(size_field);
      end
      sb_beat.start = 1'b1;
      sb_beat.data  = lzwd_pkg::BYTE_W'($urandom());
      beats.push_back(sb_beat);
      sb_beat.start = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sb_beat.data = size_field[8*i +: 8];
         beats.push_back(sb_beat);
      end
      produced = 0;
      while (produced < target) begin
         flags        = 8'($urandom());
         sb_beat.data = flags;
         beats.push_back(sb_beat);
         for (int b = 7; b >= 0; b--) begin
            if (produced < target) begin
               if (flags[b]) begin
                  len_code     = 4'($urandom());
                  dist_code    = lzwd_pkg::DIST_W'(pick_distance() - 1);
                  sb_beat.data = {len_code, dist_code[11:8]};
                  beats.push_back(sb_beat);
                  sb_beat.data = dist_code[7:0];
                  beats.push_back(sb_beat);
                  produced += int'(len_code) + lzwd_pkg::LEN_BIAS;
               end else begin
                  sb_beat.data = lzwd_pkg::BYTE_W'($urandom());
                  beats.push_back(sb_beat);
                  produced++;
               end
            end
         end
      end
      // A broken stream: the tail is dropped and the next header takes over.
      if ($urandom_range(0, 9) == 0 && beats.size() > 6)
         beats = beats[0:$urandom_range(4, beats.size() - 2)];
   endfunction

   initial begin
      stream_beat_type beats[$];
      int              counted;
      int              noise_len;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = '0;
      req_stream_start = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: a byte before any header, then a header of size zero and a byte after it.
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b1); send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      // Size five: a literal, then the longest copy at the furthest distance, which reads
      // cleared history and is cut short at the end of the stream.
      send_beat(8'h00, 1'b1); send_beat(8'h05, 1'b0);
      send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
      send_beat(8'h40, 1'b0); send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b0);
      // The largest size, two literals, then a new header that aborts it.
      send_beat(8'h10, 1'b1); send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
      send_beat(8'h80, 1'b0);
      // Size three filled by the shortest copy at distance one.
      send_beat(8'h01, 1'b1); send_beat(8'h03, 1'b0);
      send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
      send_beat(8'h80, 1'b0); send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      drain_outputs();

      // Random streams over four idling phases, draining between them.
      counted = 0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         while (counted < (ph + 1) * RANDOM_BEATS / 4) begin
            // Now and then some stray bytes go ahead of the next header.
            if ($urandom_range(0, 99) < 15) begin
               noise_len = int'($urandom_range(1, 3));
               repeat (noise_len) send_beat(lzwd_pkg::BYTE_W'($urandom()), 1'b0);
            end
            build_stream(beats);
            foreach (beats[i])
               send_beat(beats[i].data, beats[i].start);
            counted += beats.size();
         end
         drain_outputs();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d input beats in %0d streams with %0d copies,",
               sb.beats_seen, sb.streams_opened, sb.copies_decoded);
      $display("and checked %0d output bytes under four idling mixes.", sb.bytes_checked);
      if (sb.errors == 0)
         $display("lz77_window_decompressor_tb: clean");
      else
         $display("lz77_window_decompressor_tb: errors");
      $finish;
   end

endmodule

[filelist.f]
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lz77_window_decompressor.sv
rtl/lzwd_checker.sv
bench/lz77_window_decompressor_tb.sv
